### design/thc_pkg.sv
// Shared types, codes and constants for the twelve-hour clock block.
// Holds the mode codes, register indexes, reset values and segment decoder.
// No dependencies.
package thc_pkg;

  localparam logic [1:0] MODE_RUN  = 2'd0;
  localparam logic [1:0] MODE_HOUR = 2'd1;
  localparam logic [1:0] MODE_MIN  = 2'd2;

  localparam logic [1:0] CFG_TICKS_PER_MINUTE = 2'd0;
  localparam logic [1:0] CFG_IDLE_TIMEOUT     = 2'd1;
  localparam logic [1:0] CFG_PRESSES_TO_SET   = 2'd2;

  localparam logic [7:0] TICKS_PER_MINUTE_RST = 8'd240;
  localparam logic [7:0] IDLE_TIMEOUT_RST     = 8'd80;
  localparam logic [1:0] PRESSES_TO_SET_RST   = 2'd3;

  localparam logic [3:0] HOUR_RST     = 4'd12;
  localparam logic [6:0] SEG_DIGIT0   = 7'h7E;
  localparam logic [6:0] SEG_DIGIT2   = 7'h6D;
  localparam logic [6:0] SEG_BLANK    = 7'h00;

  typedef struct packed {
    logic [7:0] ticks_per_minute;
    logic [7:0] idle_timeout;
    logic [1:0] presses_to_set;
  } thc_cfg_t;

  typedef struct packed {
    logic [3:0] minute_ones;
    logic [2:0] minute_tens;
    logic [3:0] hour_value;
    logic [1:0] mode;
    logic [6:0] minute_ones_segs;
    logic [6:0] minute_tens_segs;
    logic       hour_tens_on;
    logic [6:0] hour_ones_segs;
  } thc_result_t;

  function automatic logic [6:0] seg7(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0: pat = 7'h7E;
      4'd1: pat = 7'h30;
      4'd2: pat = 7'h6D;
      4'd3: pat = 7'h79;
      4'd4: pat = 7'h33;
      4'd5: pat = 7'h5B;
      4'd6: pat = 7'h5F;
      4'd7: pat = 7'h70;
      4'd8: pat = 7'h7F;
      4'd9: pat = 7'h7B;
      default: pat = SEG_BLANK;
    endcase
    return pat;
  endfunction

endpackage

### design/thc_cfg.sv
// Configuration register file of the twelve-hour clock.
// Depends on thc_pkg for register indexes, reset values and thc_cfg_t.
module thc_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [7:0]         wr_data,
  output thc_pkg::thc_cfg_t  cfg
);
  import thc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_minute <= TICKS_PER_MINUTE_RST;
      cfg.idle_timeout     <= IDLE_TIMEOUT_RST;
      cfg.presses_to_set   <= PRESSES_TO_SET_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_TICKS_PER_MINUTE: cfg.ticks_per_minute <= wr_data;
        CFG_IDLE_TIMEOUT:     cfg.idle_timeout     <= wr_data;
        CFG_PRESSES_TO_SET:   cfg.presses_to_set   <= wr_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

### design/thc_core.sv
// Per-tick clock state and its single-pass update logic.
// Depends on thc_pkg for codes, reset values, seg7 and the cfg/result structs.
module thc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic                  left_level,
  input  logic                  right_level,
  input  thc_pkg::thc_cfg_t     cfg,
  output thc_pkg::thc_result_t  result
);
  import thc_pkg::*;

  logic       prev_left, prev_right, blink_phase;
  logic [7:0] tick_count, idle_count;
  logic [1:0] left_press_count, clock_mode;
  logic [3:0] hour_reg, min_ones_reg;
  logic [2:0] min_tens_reg;
  logic [6:0] disp_hour_ones, disp_min_tens, disp_min_ones;
  logic       disp_hour_tens;

  logic       blink_phase_next;
  logic [7:0] tick_count_next, idle_count_next;
  logic [1:0] left_press_count_next, clock_mode_next;
  logic [3:0] hour_reg_next, min_ones_reg_next;
  logic [2:0] min_tens_reg_next;
  logic [6:0] disp_hour_ones_next, disp_min_tens_next, disp_min_ones_next;
  logic       disp_hour_tens_next;

  logic       left_press, right_press;
  logic [8:0] idle_sum, tick_sum;
  logic [3:0] hour_inc, ones_inc;
  logic [2:0] tens_inc;
  logic       min_wrap;

  assign left_press  = !left_level && prev_left;
  assign right_press = !right_level && prev_right;
  assign idle_sum    = {1'b0, idle_count} + 9'd1;
  assign tick_sum    = {1'b0, tick_count} + 9'd1;
  assign hour_inc    = (hour_reg >= 4'd12) ? 4'd1 : hour_reg + 4'd1;

  always_comb begin
    ones_inc = min_ones_reg + 4'd1;
    tens_inc = min_tens_reg;
    min_wrap = 1'b0;
    if (min_ones_reg >= 4'd9) begin
      ones_inc = 4'd0;
      if (min_tens_reg >= 3'd5) begin
        tens_inc = 3'd0;
        min_wrap = 1'b1;
      end else begin
        tens_inc = min_tens_reg + 3'd1;
      end
    end
  end

  always_comb begin
    blink_phase_next      = ~blink_phase;
    tick_count_next       = tick_count;
    idle_count_next       = idle_count;
    left_press_count_next = left_press_count;
    clock_mode_next       = clock_mode;
    hour_reg_next         = hour_reg;
    min_tens_reg_next     = min_tens_reg;
    min_ones_reg_next     = min_ones_reg;
    disp_hour_ones_next   = disp_hour_ones;
    disp_hour_tens_next   = disp_hour_tens;
    disp_min_tens_next    = disp_min_tens;
    disp_min_ones_next    = disp_min_ones;

    if (!left_press && !right_press) begin
      if (idle_sum >= {1'b0, cfg.idle_timeout}) begin
        clock_mode_next       = MODE_RUN;
        left_press_count_next = 2'd0;
        idle_count_next       = cfg.idle_timeout;
        disp_min_ones_next    = seg7(min_ones_reg);
        disp_min_tens_next    = seg7({1'b0, min_tens_reg});
        disp_hour_tens_next   = (hour_reg >= 4'd10);
        disp_hour_ones_next   = seg7((hour_reg >= 4'd10) ? hour_reg - 4'd10 : hour_reg);
      end else begin
        idle_count_next = idle_sum[7:0];
      end
    end
    if (left_press) begin
      if (left_press_count != 2'd3) left_press_count_next = left_press_count + 2'd1;
      idle_count_next = 8'd0;
    end
    if (right_press) idle_count_next = 8'd0;

    case (clock_mode_next)
      MODE_RUN: begin
        if (left_press_count_next >= cfg.presses_to_set) begin
          clock_mode_next = MODE_HOUR;
          tick_count_next = 8'd0;
        end else if (tick_sum >= {1'b0, cfg.ticks_per_minute}) begin
          tick_count_next   = 8'd0;
          min_ones_reg_next = ones_inc;
          min_tens_reg_next = tens_inc;
          if (min_wrap) hour_reg_next = hour_inc;
          disp_min_ones_next  = seg7(ones_inc);
          disp_min_tens_next  = seg7({1'b0, tens_inc});
          disp_hour_tens_next = (hour_reg_next >= 4'd10);
          disp_hour_ones_next = seg7((hour_reg_next >= 4'd10) ?
                                     hour_reg_next - 4'd10 : hour_reg_next);
        end else begin
          tick_count_next = tick_sum[7:0];
        end
      end
      MODE_HOUR: begin
        if (right_press) begin
          clock_mode_next  = MODE_MIN;
          blink_phase_next = 1'b1;
        end else if (left_press) begin
          hour_reg_next = hour_inc;
        end
        if (blink_phase_next) begin
          disp_hour_tens_next = (hour_reg_next >= 4'd10);
          disp_hour_ones_next = seg7((hour_reg_next >= 4'd10) ?
                                     hour_reg_next - 4'd10 : hour_reg_next);
        end else begin
          disp_hour_ones_next = SEG_BLANK;
          disp_hour_tens_next = 1'b0;
        end
      end
      MODE_MIN: begin
        if (right_press) begin
          blink_phase_next      = 1'b1;
          clock_mode_next       = MODE_RUN;
          left_press_count_next = 2'd0;
        end else if (left_press) begin
          min_ones_reg_next = ones_inc;
          min_tens_reg_next = tens_inc;
        end
        if (blink_phase_next) begin
          disp_min_ones_next = seg7(min_ones_reg_next);
          disp_min_tens_next = seg7({1'b0, min_tens_reg_next});
        end else begin
          disp_min_ones_next = SEG_BLANK;
          disp_min_tens_next = SEG_BLANK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left        <= 1'b0;
      prev_right       <= 1'b0;
      blink_phase      <= 1'b0;
      tick_count       <= 8'd0;
      idle_count       <= 8'd0;
      left_press_count <= 2'd0;
      clock_mode       <= MODE_RUN;
      hour_reg         <= HOUR_RST;
      min_tens_reg     <= 3'd0;
      min_ones_reg     <= 4'd0;
      disp_hour_ones   <= SEG_DIGIT2;
      disp_hour_tens   <= 1'b1;
      disp_min_tens    <= SEG_DIGIT0;
      disp_min_ones    <= SEG_DIGIT0;
    end else if (step) begin
      prev_left        <= left_level;
      prev_right       <= right_level;
      blink_phase      <= blink_phase_next;
      tick_count       <= tick_count_next;
      idle_count       <= idle_count_next;
      left_press_count <= left_press_count_next;
      clock_mode       <= clock_mode_next;
      hour_reg         <= hour_reg_next;
      min_tens_reg     <= min_tens_reg_next;
      min_ones_reg     <= min_ones_reg_next;
      disp_hour_ones   <= disp_hour_ones_next;
      disp_hour_tens   <= disp_hour_tens_next;
      disp_min_tens    <= disp_min_tens_next;
      disp_min_ones    <= disp_min_ones_next;
    end
  end

  assign result.hour_ones_segs   = disp_hour_ones_next;
  assign result.hour_tens_on     = disp_hour_tens_next;
  assign result.minute_tens_segs = disp_min_tens_next;
  assign result.minute_ones_segs = disp_min_ones_next;
  assign result.mode             = clock_mode_next;
  assign result.hour_value       = hour_reg_next;
  assign result.minute_tens      = min_tens_reg_next;
  assign result.minute_ones      = min_ones_reg_next;

endmodule

### design/twelve_hour_clock_with_button_set_top.sv
// Top level of the twelve-hour clock: input register, clock core, result register.
// Depends on thc_pkg, thc_cfg and thc_core.
//
//   channel  | direction | signals                        | content
//   s_axis   | in        | s_tvalid s_tready s_tdata[7:0] | one tick with two button levels
//   m_axis   | out       | m_tvalid m_tready m_tdata[39:0]| display patterns and time
//   cfg      | in        | cfg_valid cfg_ready cfg_index  | register writes, always ready
//
// One tick per cycle sustained while m_tready stays high; a tick's result reaches m_tdata:
// the input register loads at the transfer, the core update loads the result register at fire.
// Reset clears both valid flags and loads 12:00 in run mode with default registers.
// A stall on m_tready holds the result register and backs up into the input register.
module twelve_hour_clock_with_button_set_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] left_level, [1] right_level, [7:2] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [6:0] hour_ones_segs, [7] hour_tens_on,
                                 // [14:8] minute_tens_segs, [21:15] minute_ones_segs,
                                 // [23:22] mode, [27:24] hour_value,
                                 // [30:28] minute_tens, [34:31] minute_ones, [39:35] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import thc_pkg::*;

  logic        in_valid;
  logic        in_left, in_right;
  logic        fire;
  thc_cfg_t    cfg;
  thc_result_t result;

  assign fire      = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_left  <= s_tdata[0];
      in_right <= s_tdata[1];
    end
  end

  thc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  thc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (fire),
    .left_level  (in_left),
    .right_level (in_right),
    .cfg         (cfg),
    .result      (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {5'd0, result};
    end
  end

endmodule

### design/thc_chk.sv
// Port-level checker for the twelve-hour clock top level, with its bind.
// Depends on thc_pkg for the mode codes.
module thc_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  import thc_pkg::*;

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_mode: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[23:22] == MODE_RUN || m_tdata[23:22] == MODE_HOUR ||
                    m_tdata[23:22] == MODE_MIN))
    else $error("bad mode code");

  a_time: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> (m_tdata[27:24] != 4'd0 && m_tdata[27:24] <= 4'd12 &&
                    m_tdata[30:28] <= 3'd5 && m_tdata[34:31] <= 4'd9))
    else $error("time out of range");

  a_run_lit: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tdata[23:22] == MODE_RUN |-> m_tdata[21:15] != 7'd0 &&
      m_tdata[14:8] != 7'd0)
    else $error("minute digits blank in run mode");

endmodule

bind twelve_hour_clock_with_button_set_top thc_chk u_thc_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### tb/tb_twelve_hour_clock_with_button_set_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for twelve_hour_clock_with_button_set_top: directed button
// sequences, then randomized press sessions under several register settings.
// Depends on thc_pkg and the clock RTL; predicts every display result internally.
module tb_twelve_hour_clock_with_button_set_top;
  import thc_pkg::*;

  localparam int PHASE_TICKS    = 250;
  localparam int NUM_PHASES     = 8;
  localparam int LONG_HOLD      = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;

  // {right_level, left_level} per directed tick
  localparam logic [0:24][1:0] DIRECTED_LEVELS = {
    2'b00, 2'b11, 2'b00, 2'b01, 2'b00, 2'b01, 2'b00, 2'b11, 2'b10, 2'b11,
    2'b10, 2'b11, 2'b00, 2'b01, 2'b00, 2'b11, 2'b01, 2'b00, 2'b00, 2'b00,
    2'b00, 2'b00, 2'b00, 2'b11, 2'b00
  };

  typedef struct {
    logic        left;
    logic        right;
    bit          has_exp;
    thc_result_t exp;
  } tick_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [0] left_level, [1] right_level, [7:2] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [6:0] hour_ones_segs, [7] hour_tens_on,
                               // [14:8] minute_tens_segs, [21:15] minute_ones_segs,
                               // [23:22] mode, [27:24] hour_value,
                               // [30:28] minute_tens, [34:31] minute_ones
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  twelve_hour_clock_with_button_set_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // clock state mirror
  logic [7:0] cfg_tpm, cfg_idle;
  logic [1:0] cfg_presses;
  logic       last_left, last_right, blink;
  logic [7:0] tick_cnt, quiet_cnt;
  logic [1:0] press_cnt, cur_mode;
  logic [3:0] hr_r, mo_r;
  logic [2:0] mt_r;
  logic [6:0] seg_ho, seg_mt, seg_mo;
  logic       seg_ht;

  tick_item_t  tick_q[$];
  thc_result_t predicted_views[$];
  tick_item_t  drv_item;
  int          fail_cnt = 0;
  int          ticks_sent = 0;
  int          results_seen = 0;
  int          settings_used = 0;
  int          stall_cycles = 0;
  bit          src_calm = 1'b0;
  bit          hold_req = 1'b0;

  function automatic logic [6:0] digit_pattern(input int d);
    case (d)
      0: return 7'h7E;
      1: return 7'h30;
      2: return 7'h6D;
      3: return 7'h79;
      4: return 7'h33;
      5: return 7'h5B;
      6: return 7'h5F;
      7: return 7'h70;
      8: return 7'h7F;
      9: return 7'h7B;
      default: return 7'h00;
    endcase
  endfunction

  function automatic void clear_clock();
    cfg_tpm = TICKS_PER_MINUTE_RST;
    cfg_idle = IDLE_TIMEOUT_RST;
    cfg_presses = PRESSES_TO_SET_RST;
    last_left = 0;
    last_right = 0;
    blink = 0;
    tick_cnt = 0;
    quiet_cnt = 0;
    press_cnt = 0;
    cur_mode = MODE_RUN;
    hr_r = HOUR_RST;
    mt_r = 0;
    mo_r = 0;
    seg_ho = SEG_DIGIT2;
    seg_ht = 1;
    seg_mt = SEG_DIGIT0;
    seg_mo = SEG_DIGIT0;
  endfunction

  function automatic void refresh_hours();
    if (hr_r < 10) begin
      seg_ho = digit_pattern(hr_r);
      seg_ht = 0;
    end else begin
      seg_ho = digit_pattern(hr_r - 10);
      seg_ht = 1;
    end
  endfunction

  function automatic void refresh_minutes();
    seg_mo = digit_pattern(mo_r);
    seg_mt = digit_pattern(mt_r);
  endfunction

  function automatic void bump_hour();
    if (hr_r >= 12) hr_r = 1;
    else hr_r = hr_r + 1;
  endfunction

  function automatic bit bump_minute();
    bit wrapped;
    wrapped = 0;
    if (mo_r >= 9) begin
      mo_r = 0;
      if (mt_r >= 5) begin
        mt_r = 0;
        wrapped = 1;
      end else begin
        mt_r = mt_r + 1;
      end
    end else begin
      mo_r = mo_r + 1;
    end
    return wrapped;
  endfunction

  function automatic thc_result_t advance_clock_tick(input logic left, input logic right);
    thc_result_t r;
    bit lp, rp;
    lp = !left && last_left;
    rp = !right && last_right;
    last_left = left;
    last_right = right;
    blink = ~blink;
    if (!lp && !rp) begin
      if (int'(quiet_cnt) + 1 >= int'(cfg_idle)) begin
        cur_mode = MODE_RUN;
        press_cnt = 0;
        quiet_cnt = cfg_idle;
        refresh_minutes();
        refresh_hours();
      end else begin
        quiet_cnt = quiet_cnt + 1;
      end
    end
    if (lp) begin
      if (press_cnt < 3) press_cnt = press_cnt + 1;
      quiet_cnt = 0;
    end
    if (rp) quiet_cnt = 0;
    case (cur_mode)
      MODE_RUN: begin
        if (press_cnt >= cfg_presses) begin
          cur_mode = MODE_HOUR;
          tick_cnt = 0;
        end else if (int'(tick_cnt) + 1 >= int'(cfg_tpm)) begin
          tick_cnt = 0;
          if (bump_minute()) bump_hour();
          refresh_minutes();
          refresh_hours();
        end else begin
          tick_cnt = tick_cnt + 1;
        end
      end
      MODE_HOUR: begin
        if (rp) begin
          cur_mode = MODE_MIN;
          blink = 1;
        end else if (lp) begin
          bump_hour();
        end
        if (blink) begin
          refresh_hours();
        end else begin
          seg_ho = SEG_BLANK;
          seg_ht = 0;
        end
      end
      MODE_MIN: begin
        if (rp) begin
          blink = 1;
          cur_mode = MODE_RUN;
          press_cnt = 0;
        end else if (lp) begin
          void'(bump_minute());
        end
        if (blink) begin
          refresh_minutes();
        end else begin
          seg_mo = SEG_BLANK;
          seg_mt = SEG_BLANK;
        end
      end
      default: ;
    endcase
    r.hour_ones_segs = seg_ho;
    r.hour_tens_on = seg_ht;
    r.minute_tens_segs = seg_mt;
    r.minute_ones_segs = seg_mo;
    r.mode = cur_mode;
    r.hour_value = hr_r;
    r.minute_tens = mt_r;
    r.minute_ones = mo_r;
    return r;
  endfunction

  function automatic string fmt_view(input thc_result_t r);
    return $sformatf("ho=%02h ht=%0d mt=%02h mo=%02h mode=%0d time=%0d:%0d%0d",
                     r.hour_ones_segs, r.hour_tens_on, r.minute_tens_segs,
                     r.minute_ones_segs, r.mode, r.hour_value, r.minute_tens,
                     r.minute_ones);
  endfunction

  // stimulus builders
  function automatic void add_tick(input logic left, input logic right);
    tick_item_t it;
    it.left = left;
    it.right = right;
    it.has_exp = 0;
    it.exp = '0;
    tick_q.push_back(it);
  endfunction

  function automatic void add_click(input logic left, input logic right);
    repeat ($urandom_range(1, 2)) add_tick(left, right);
    repeat ($urandom_range(1, 2)) add_tick(1'b0, 1'b0);
  endfunction

  function automatic void add_quiet(input int len);
    logic [1:0] lv;
    lv = $urandom_range(0, 3);
    repeat (len) add_tick(lv[0], lv[1]);
  endfunction

  function automatic int long_quiet();
    int n;
    n = int'(cfg_idle) + $urandom_range(1, 3);
    return (n > 300) ? 300 : n;
  endfunction

  function automatic void add_session();
    int steps;
    repeat (int'(cfg_presses) + $urandom_range(0, 1)) add_click(1'b1, 1'b0);
    repeat ($urandom_range(0, 14)) add_click(1'b1, 1'b0);
    if ($urandom_range(0, 7) == 0) add_quiet(long_quiet());
    if ($urandom_range(0, 3) == 0) add_click(1'b1, 1'b1);
    else add_click(1'b0, 1'b1);
    steps = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 6);
    repeat (steps) add_click(1'b1, 1'b0);
    if ($urandom_range(0, 5) == 0) add_quiet(long_quiet());
    else add_click(1'b0, 1'b1);
  endfunction

  function automatic void build_phase();
    int pick;
    while (tick_q.size() < PHASE_TICKS) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) add_session();
      else if (pick < 65) add_click($urandom_range(0, 1), $urandom_range(0, 1));
      else if (pick < 85) add_quiet(($urandom_range(0, 4) == 0) ? long_quiet()
                                                                : $urandom_range(1, 8));
      else repeat ($urandom_range(1, 10)) add_tick($urandom_range(0, 1),
                                                   $urandom_range(0, 1));
    end
  endfunction

  function automatic int pick_gap();
    int p;
    if (src_calm) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_ticks();
    tick_item_t it;
    int gap;
    while (tick_q.size() > 0) begin
      it = tick_q.pop_front();
      gap = pick_gap();
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata <= {6'b0, it.right, it.left};
      drv_item <= it;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (predicted_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_TICKS_PER_MINUTE: cfg_tpm = val;
      CFG_IDLE_TIMEOUT:     cfg_idle = val;
      CFG_PRESSES_TO_SET:   cfg_presses = val[1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(input logic [7:0] tpm, input logic [7:0] idle,
                               input logic [1:0] presses);
    reg_write(CFG_TICKS_PER_MINUTE, tpm);
    reg_write(CFG_IDLE_TIMEOUT, idle);
    reg_write(CFG_PRESSES_TO_SET, {6'b0, presses});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // predict on every input transfer
  always @(posedge clk) begin
    thc_result_t want;
    if (!rst && s_tvalid && s_tready) begin
      want = advance_clock_tick(drv_item.left, drv_item.right);
      if (drv_item.has_exp) want = drv_item.exp;
      predicted_views.push_back(want);
      ticks_sent++;
    end
  end

  // check every output transfer
  always @(posedge clk) begin
    thc_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[34:0];
      results_seen++;
      if (predicted_views.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("unexpected result: %s", fmt_view(got));
      end else begin
        want = predicted_views.pop_front();
        if (got !== want) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("mismatch at result %0d\n  exp %s\n  got %s",
                     results_seen, fmt_view(want), fmt_view(got));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results pending",
                 stall_cycles, predicted_views.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // output backpressure
  initial begin
    int on_len, off_len;
    while (rst) @(posedge clk);
    forever begin
      on_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
      case ($urandom_range(0, 19))
        0, 1, 2:    off_len = $urandom_range(5, 30);
        3, 4, 5, 6, 7, 8, 9: off_len = $urandom_range(1, 3);
        default:    off_len = 0;
      endcase
      if (hold_req) begin
        off_len = LONG_HOLD;
        hold_req = 0;
      end
      m_tready <= 1'b1;
      repeat (on_len) @(posedge clk);
      if (off_len > 0) begin
        m_tready <= 1'b0;
        repeat (off_len) @(posedge clk);
      end
    end
  end

  initial begin
    tick_item_t it;
    logic [7:0] tpm_set [NUM_PHASES];
    logic [7:0] idle_set [NUM_PHASES];
    logic [1:0] press_set [NUM_PHASES];
    thc_result_t reset_view;

    tpm_set = '{8'd255, 8'd1, 8'd0, 8'd1, 8'd255, 8'd0, 8'd2, TICKS_PER_MINUTE_RST};
    idle_set = '{8'd255, 8'd1, 8'd0, 8'd255, 8'd1, 8'd0, 8'd20, IDLE_TIMEOUT_RST};
    press_set = '{2'd3, 2'd1, 2'd0, 2'd1, 2'd2, 2'd0, 2'd3, PRESSES_TO_SET_RST};
    tpm_set[5] = $urandom_range(2, 30);
    idle_set[5] = $urandom_range(5, 40);
    press_set[5] = $urandom_range(1, 3);

    clear_clock();
    drv_item.left = 0;
    drv_item.right = 0;
    drv_item.has_exp = 0;
    drv_item.exp = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_settings(8'd3, 8'd6, 2'd3);
    reset_view.hour_ones_segs = SEG_DIGIT2;
    reset_view.hour_tens_on = 1'b1;
    reset_view.minute_tens_segs = SEG_DIGIT0;
    reset_view.minute_ones_segs = SEG_DIGIT0;
    reset_view.mode = MODE_RUN;
    reset_view.hour_value = HOUR_RST;
    reset_view.minute_tens = 3'd0;
    reset_view.minute_ones = 4'd0;
    for (int i = 0; i < 25; i++) begin
      it.left = DIRECTED_LEVELS[i][0];
      it.right = DIRECTED_LEVELS[i][1];
      it.has_exp = (i == 0);
      it.exp = reset_view;
      tick_q.push_back(it);
    end
    send_ticks();
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_settings(tpm_set[p], idle_set[p], press_set[p]);
      src_calm = ($urandom_range(0, 3) == 0);
      if (p == 2) begin
        src_calm = 1'b1;
        hold_req = 1'b1;
      end
      build_phase();
      send_ticks();
      drain();
    end

    $display("covered %0d ticks over %0d register settings, %0d results checked",
             ticks_sent, settings_used, results_seen);
    $display("press sessions, idle timeouts, minute and hour wraps, long output stall");
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
